// ----- rtl/qcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// qcpa_pkg: shared types and constants
// Payload structs, lane control struct and the quaternion product tables
// for the conjugate-product accumulator.
// ----------------------------------------------------------------------------
package qcpa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int PSUM_W   = PROD_W + 2;
  localparam int SUM_W    = ((ACC_W > PSUM_W) ? ACC_W : PSUM_W) + 1;
  localparam int LANES    = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [PSUM_W-1:0]   psum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef sample_t [LANES-1:0]        quat_t;
  typedef acc_t [LANES-1:0]           acc_vec_t;

  // Bit m set means product m of that component enters with a minus sign.
  localparam logic [LANES-1:0] NEG_MASK [LANES] = '{4'b0000, 4'b0110, 4'b1100, 4'b1010};

  typedef struct packed {
    sample_t in_real;
    sample_t in_i;
    sample_t in_j;
    sample_t in_k;
    sample_t grad_real;
    sample_t grad_i;
    sample_t grad_j;
    sample_t grad_k;
    logic    last_term;
  } pair_t;

  typedef struct packed {
    acc_t sum_real;
    acc_t sum_i;
    acc_t sum_j;
    acc_t sum_k;
    logic saturated;
  } result_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
    logic acc_en;
    logic clear;
  } lane_ctl_t;

  // Component c of conj(p)*q pairs p[m] with q[m xor c].
  function automatic logic [1:0] q_index(input logic [1:0] c, input logic [1:0] m);
    return c ^ m;
  endfunction

endpackage

// ----- rtl/quaternion_conj_product_accumulator.sv -----
// ----------------------------------------------------------------------------
// quaternion_conj_product_accumulator: quaternion weight-gradient MAC
// The result is registered once the closing request has passed the product, sum and accumulate stages.
// Throughput: one request per cycle, set by the multiply, sum and accumulate stages.
// Requests stall only while a closing term waits for the held result to be taken.
// Reset clears the accumulators, the saturation flag, transpose mode and all valids.
// ----------------------------------------------------------------------------
module quaternion_conj_product_accumulator
  import qcpa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  input  logic    pair_valid,
  output logic    pair_ready,
  input  pair_t   pair,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic             transpose_mode;
  logic             p_valid;
  logic             p_last;
  logic             s_valid;
  logic             s_last;
  logic             s_go;
  logic             s_adv;
  logic             p_go;
  logic             accept;
  logic             out_free;
  quat_t            qa;
  quat_t            qb;
  quat_t            p_sel;
  quat_t            q_sel;
  lane_ctl_t        ctl;
  acc_vec_t         lane_sum;
  logic [LANES-1:0] lane_clip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose_mode <= 1'b0;
    end else if (cfg_valid) begin
      transpose_mode <= cfg_data;
    end
  end

  assign qa    = {pair.in_k, pair.in_j, pair.in_i, pair.in_real};
  assign qb    = {pair.grad_k, pair.grad_j, pair.grad_i, pair.grad_real};
  assign p_sel = transpose_mode ? qb : qa;
  assign q_sel = transpose_mode ? qa : qb;

  assign s_go       = s_valid && (!s_last || out_free);
  assign s_adv      = !s_valid || s_go;
  assign p_go       = p_valid && s_adv;
  assign pair_ready = !p_valid || p_go;
  assign accept     = pair_valid && pair_ready;

  assign ctl.prod_en = accept;
  assign ctl.sum_en  = p_go;
  assign ctl.acc_en  = s_go;
  assign ctl.clear   = s_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (pair_ready) begin
        p_valid <= accept;
      end
      if (s_adv) begin
        s_valid <= p_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_last <= pair.last_term;
    end
    if (p_go) begin
      s_last <= p_last;
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    qcpa_lane #(
      .LANE(c)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .p        (p_sel),
      .q        (q_sel),
      .acc_next (lane_sum[c]),
      .clip     (lane_clip[c])
    );
  end

  qcpa_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .lane_sum     (lane_sum),
    .lane_clip    (lane_clip),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_free     (out_free)
  );

`ifndef ASSERT_OFF
  a_empty_takes_request: assert property (@(posedge clk) disable iff (rst)
    !p_valid |-> pair_ready)
    else $error("Empty product stage refused a request.");

  a_last_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_last && result_valid && !result_ready) |-> !ctl.acc_en)
    else $error("Closing term overwrote a held result.");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (ctl.acc_en && ctl.clear) |=> result_valid)
    else $error("Closing term produced no result.");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !s_go) |=> s_valid)
    else $error("Stalled accumulate stage lost its term.");
`endif

endmodule

// ----- rtl/qcpa_lane.sv -----
// ----------------------------------------------------------------------------
// qcpa_lane: one quaternion component
// Four multipliers, a signed four-term sum and a saturating accumulator
// for one component of the conjugate product.
// ----------------------------------------------------------------------------
module qcpa_lane
  import qcpa_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  quat_t     p,
  input  quat_t     q,
  output acc_t      acc_next,
  output logic      clip
);

  localparam logic [1:0]       LANE_ID = LANE[1:0];
  localparam logic [LANES-1:0] NEG     = NEG_MASK[LANE];

  prod_t             prod [LANES];
  psum_t             psum;
  psum_t             psum_next;
  acc_t              acc;
  logic signed [SUM_W-1:0] total;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int m = 0; m < LANES; m++) begin
        prod[m] <= $signed(p[m]) * $signed(q[q_index(LANE_ID, 2'(m))]);
      end
    end
    if (ctl.sum_en) begin
      psum <= psum_next;
    end
  end

  always_comb begin
    psum_next = '0;
    for (int m = 0; m < LANES; m++) begin
      if (NEG[m]) begin
        psum_next = psum_next - PSUM_W'(prod[m]);
      end else begin
        psum_next = psum_next + PSUM_W'(prod[m]);
      end
    end
  end

  always_comb begin
    total = SUM_W'(acc) + SUM_W'(psum);
    clip  = (total[SUM_W-1:ACC_W-1] != '0) && (total[SUM_W-1:ACC_W-1] != '1);
    if (!clip) begin
      acc_next = total[ACC_W-1:0];
    end else if (total[SUM_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= ctl.clear ? '0 : acc_next;
    end
  end

endmodule

// ----- rtl/qcpa_merge.sv -----
// ----------------------------------------------------------------------------
// qcpa_merge: lane merge and result register
// Collects the four lane sums, keeps the sticky saturation flag and holds
// the finished result until it is taken.
// ----------------------------------------------------------------------------
module qcpa_merge
  import qcpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  acc_vec_t         lane_sum,
  input  logic [LANES-1:0] lane_clip,
  output result_t          result,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             out_free
);

  logic clip_seen;
  logic emit;

  assign emit     = ctl.acc_en && ctl.clear;
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_seen    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.acc_en) begin
        clip_seen <= ctl.clear ? 1'b0 : (clip_seen || (|lane_clip));
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.sum_real  <= lane_sum[0];
      result.sum_i     <= lane_sum[1];
      result.sum_j     <= lane_sum[2];
      result.sum_k     <= lane_sum[3];
      result.saturated <= clip_seen || (|lane_clip);
    end
  end

endmodule
